/* src/quadrature_encoder_with_button_unit_defines.svh */
// assertion macros used by the checker file
`ifndef QUADRATURE_ENCODER_WITH_BUTTON_UNIT_DEFINES_SVH
`define QUADRATURE_ENCODER_WITH_BUTTON_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define QEWB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qewb assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define QEWB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qewb assertion failed");

`endif

/* src/qewb_pkg.sv */
`default_nettype none

package qewb_pkg;

  // word layouts
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 24;
  localparam int ROT_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRANSITIONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd1;

  localparam logic [2:0]  TPS_RESET      = 3'd4;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

  typedef logic signed [1:0] dir_t;

  // quadrature decode: index is {prev_ab, ab}
  function automatic dir_t quad_dir(input logic [3:0] idx);
    dir_t d;
    d = 2'sd0;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = -2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* src/quadrature_encoder_with_button_unit.sv */
`default_nettype none
// quadrature encoder decoder with a debounced push button
// input stream s_*: one word per sampled tick, tdata = {take, button_event, ab_lines}
//   ab_lines bit1 is line A, bit0 is line B; take reads and clears the pending values
// output stream m_*: one word per input word, tdata = {click_seen, rotation_steps}
//   rotation_steps is the signed pending detent count after the tick's update
// config: cfg_we writes cfg_data into register cfg_index at the clock edge
//   index 0 transitions per detent, index 1 debounce_ticks, other indexes ignored
// the result is registered and appears in the cycle after the word is accepted
// throughput: one word per cycle while the output is not stalled; all decode, debounce
//   and saturation logic sits between the accepting edge and the single output register
// when the receiver stalls, the output word holds and s_tready drops until it
//   is taken; a word taken in a cycle frees the slot for a new one that cycle
// reset (rst, synchronous): output empty, counts and flags cleared, the
//   press timer saturated so the first press is accepted, registers back to
//   4 transitions and 50 ticks; the first word after reset only samples A/B for rotation
module quadrature_encoder_with_button_unit
  import qewb_pkg::*;
#(
  parameter int STEP_COUNT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // [1:0] ab_lines, [2] button_event, [3] take
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,   // [15:0] rotation_steps, [16] click_seen
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int SCB = STEP_COUNT_BITS;
  localparam logic signed [SCB-1:0] CNT_MAX = {1'b0, {(SCB-1){1'b1}}};
  localparam logic signed [SCB-1:0] CNT_MIN = {1'b1, {(SCB-1){1'b0}}};

  // configuration registers
  logic [2:0]  detent_span;
  logic [15:0] debounce_ticks;

  // decoder state
  logic [1:0]            prev_ab;
  logic                  primed;
  logic signed [3:0]     sub_step_acc;
  logic signed [SCB-1:0] pending_steps;
  logic                  click_pending;
  logic [15:0]           ticks_since_press;

  // next values
  logic [1:0]            prev_ab_next;
  logic signed [3:0]     sub_step_acc_next;
  logic signed [SCB-1:0] pending_steps_next;
  logic                  click_pending_next;
  logic [15:0]           ticks_since_press_next;

  logic [1:0]            ab_lines;
  logic                  button_event;
  logic                  take;
  logic                  accept;
  logic [15:0]           ticks_inc;
  logic                  press_ok;
  logic [2:0]            tps_eff;
  logic signed [3:0]     tps_s;
  dir_t                  dir;
  logic signed [3:0]     acc_sum;
  logic signed [SCB-1:0] pending_upd;
  logic                  click_upd;
  logic signed [ROT_W-1:0] report;

  assign ab_lines     = s_tdata[1:0];
  assign button_event = s_tdata[2];
  assign take         = s_tdata[3];

  // a single output slot: free when empty or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      detent_span    <= TPS_RESET;
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRANSITIONS: detent_span    <= cfg_data[2:0];
        REG_DEBOUNCE:    debounce_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // button debounce: timer saturates, then a press is taken if far enough apart
  always_comb begin
    ticks_inc = (ticks_since_press != 16'hFFFF) ? ticks_since_press + 16'd1
                                                : ticks_since_press;
    press_ok  = button_event && (ticks_inc >= debounce_ticks);
    ticks_since_press_next = press_ok ? 16'd0 : ticks_inc;
    click_upd = click_pending || press_ok;
  end

  // step size: zero acts as one, above four acts as four
  always_comb begin
    if (detent_span == 3'd0) begin
      tps_eff = 3'd1;
    end else if (detent_span > 3'd4) begin
      tps_eff = 3'd4;
    end else begin
      tps_eff = detent_span;
    end
    tps_s = signed'({1'b0, tps_eff});
  end

  // quadrature decode and detent accumulation
  always_comb begin
    dir                = quad_dir({prev_ab, ab_lines});
    acc_sum            = sub_step_acc + 4'(dir);
    prev_ab_next       = ab_lines;
    sub_step_acc_next  = sub_step_acc;
    pending_upd        = pending_steps;
    if (primed && (ab_lines != prev_ab)) begin
      if (dir == 2'sd0) begin
        // invalid double change
        sub_step_acc_next = 4'sd0;
      end else if (acc_sum >= tps_s) begin
        sub_step_acc_next = acc_sum - tps_s;
        if (pending_steps != CNT_MAX) pending_upd = pending_steps + SCB'(1);
      end else if (acc_sum <= -tps_s) begin
        sub_step_acc_next = acc_sum + tps_s;
        if (pending_steps != CNT_MIN) pending_upd = pending_steps - SCB'(1);
      end else begin
        sub_step_acc_next = acc_sum;
      end
    end
    // take clears after reporting; the accumulator stays
    pending_steps_next = take ? '0 : pending_upd;
    click_pending_next = take ? 1'b0 : click_upd;
  end

  // report the count in 16 bits, clamped when the counter is wider
  generate
    if (SCB > ROT_W) begin : g_clamp
      localparam logic signed [SCB-1:0] REP_MAX = SCB'(32'sd32767);
      localparam logic signed [SCB-1:0] REP_MIN = SCB'(-32'sd32768);
      assign report = (pending_upd > REP_MAX) ? 16'sh7FFF :
                      (pending_upd < REP_MIN) ? 16'sh8000 :
                      pending_upd[ROT_W-1:0];
    end else begin : g_extend
      assign report = ROT_W'(pending_upd);
    end
  endgenerate

  // state update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab           <= 2'd0;
      primed            <= 1'b0;
      sub_step_acc      <= 4'sd0;
      pending_steps     <= '0;
      click_pending     <= 1'b0;
      ticks_since_press <= 16'hFFFF;
    end else if (accept) begin
      prev_ab           <= prev_ab_next;
      primed            <= 1'b1;
      sub_step_acc      <= sub_step_acc_next;
      pending_steps     <= pending_steps_next;
      click_pending     <= click_pending_next;
      ticks_since_press <= ticks_since_press_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {7'd0, click_upd, report};
    end
  end

endmodule

`default_nettype wire

/* src/qewb_checker.sv */
`default_nettype none
`include "quadrature_encoder_with_button_unit_defines.svh"

module qewb_checker
  import qewb_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [S_TDATA_W-1:0] s_tdata,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  // stalled word holds
  `QEWB_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // every accepted word shows a result next cycle
  `QEWB_ASSERT_NEXT(a_result, s_tvalid && s_tready, m_tvalid)

  // an empty output slot never blocks the input
  `QEWB_ASSERT_IMPL(a_ready, !m_tvalid, s_tready)

  // after a take, a quiet tick with the same lines reports nothing pending
  `QEWB_ASSERT_NEXT(a_take,
    (s_tvalid && s_tready && s_tdata[3]) ##1
    (s_tvalid && s_tready && !s_tdata[2] && (s_tdata[1:0] == $past(s_tdata[1:0]))),
    m_tdata[16:0] == 17'd0)

endmodule

bind quadrature_encoder_with_button_unit qewb_checker u_qewb_checker (.*);

`default_nettype wire
